// ===== design/mceb_pkg.sv =====
// Shared types and constants of the monochrome color-expansion blitter.
// Holds the word structs, the configuration register map and the queue entry.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mceb_pkg;

    localparam int DEF_MAX_GLYPH_WIDTH  = 64;
    localparam int DEF_MAX_GLYPH_HEIGHT = 64;

    // Width of the configuration write data and index.
    localparam int CFG_DW = 24;
    localparam int CFG_IW = 3;

    // Column positions fit in 14 bits for every allowed glyph size.
    localparam int X_W = 14;

    // Entries in the queue between front and back.
    localparam int Q_DEPTH = 2;

    localparam logic [2:0] BPP_RESET = 3'd4;

    typedef enum logic [CFG_IW-1:0] {
        CFG_BYTES_PER_PIXEL = 3'd0,
        CFG_LINE_STRIDE     = 3'd1,
        CFG_CLIP_RIGHT      = 3'd2,
        CFG_CLIP_BOTTOM     = 3'd3,
        CFG_BASE_OFFSET     = 3'd4,
        CFG_WRITE_DISABLE   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [11:0] origin_x;
        logic [11:0] origin_y;
        logic [6:0]  glyph_width;
        logic [6:0]  glyph_height;
        logic [31:0] fg_color;
        logic [31:0] bg_color;
        logic [7:0]  pattern_byte;
        logic [7:0]  mask_byte;
        logic        use_mask;
        logic        first_byte;
    } t_in;

    typedef struct packed {
        logic [31:0] write_offset;
        logic [31:0] write_data;
        logic [2:0]  write_bytes;
        logic        last_of_item;
    } t_out;

    typedef struct packed {
        logic [2:0]  bytes_per_pixel;
        logic [15:0] line_stride;
        logic [11:0] clip_right;
        logic [11:0] clip_bottom;
        logic [23:0] base_offset;
        logic        write_disable;
    } t_cfg;

    // One classified word: which of its eight pixels write, left to right.
    typedef struct packed {
        logic [7:0]     emit;
        logic [7:0]     sel;
        logic [X_W-1:0] x0;
        logic [31:0]    row_off;
        logic [31:0]    fg;
        logic [31:0]    bg;
        logic [2:0]     bpp;
    } t_job;

    function automatic logic [31:0] data_mask(input logic [2:0] bpp);
        logic [31:0] m;
        case (bpp)
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== design/mceb_front.sv =====
// Front end of the blitter: accepts pattern words, keeps the row and byte
// counters, clips and masks, and builds one queue entry per word that writes.
// Depends on mceb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mceb_front #(
    parameter int MAX_GLYPH_WIDTH  = mceb_pkg::DEF_MAX_GLYPH_WIDTH,
    parameter int MAX_GLYPH_HEIGHT = mceb_pkg::DEF_MAX_GLYPH_HEIGHT
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire mceb_pkg::t_in  i_item,
    input  wire mceb_pkg::t_cfg i_cfg,
    input  wire logic           i_full,
    output logic                o_stall,
    output logic                o_push,
    output mceb_pkg::t_job      o_job
);

    localparam int BPL_MAX = (MAX_GLYPH_WIDTH + 7) / 8;
    localparam int BIR_W   = (BPL_MAX > 1) ? $clog2(BPL_MAX) : 1;
    localparam int ROW_W   = $clog2(MAX_GLYPH_HEIGHT + 1);
    localparam int CMP_W   = 10;

    logic [ROW_W-1:0] r_row, n_row;
    logic [BIR_W-1:0] r_bir, n_bir;

    logic [6:0]       gw, gh;
    logic [4:0]       bpl;
    logic [ROW_W-1:0] ri0, ri1;
    logic [BIR_W-1:0] bi0, bi1;
    logic [BIR_W:0]   bi2;
    logic [12:0]      cw, ch;
    logic [12:0]      xb;
    logic [12:0]      ry;
    logic [28:0]      prod;
    logic [7:0]       emit, sel;
    logic             en, accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        if (i_item.glyph_width == 7'd0) begin
            gw = 7'd1;
        end else if (int'(i_item.glyph_width) > MAX_GLYPH_WIDTH) begin
            gw = 7'(MAX_GLYPH_WIDTH);
        end else begin
            gw = i_item.glyph_width;
        end
        if (i_item.glyph_height == 7'd0) begin
            gh = 7'd1;
        end else if (int'(i_item.glyph_height) > MAX_GLYPH_HEIGHT) begin
            gh = 7'(MAX_GLYPH_HEIGHT);
        end else begin
            gh = i_item.glyph_height;
        end
        bpl = 5'((8'(gw) + 8'd7) >> 3);

        ri0 = i_item.first_byte ? '0 : r_row;
        bi0 = i_item.first_byte ? '0 : r_bir;
        ri1 = (CMP_W'(ri0) > CMP_W'(gh)) ? ROW_W'(gh) : ri0;
        bi1 = (CMP_W'(bi0) >= CMP_W'(bpl)) ? '0 : bi0;
        xb  = 13'({bi1, 3'b000});

        // Visible extent after clipping; zero when the origin is at or past the edge.
        if (i_item.origin_x >= i_cfg.clip_right) begin
            cw = '0;
        end else if (13'(i_item.origin_x) + 13'(gw) > 13'(i_cfg.clip_right)) begin
            cw = 13'(i_cfg.clip_right - i_item.origin_x);
        end else begin
            cw = 13'(gw);
        end
        if (i_item.origin_y >= i_cfg.clip_bottom) begin
            ch = '0;
        end else if (13'(i_item.origin_y) + 13'(gh) > 13'(i_cfg.clip_bottom)) begin
            ch = 13'(i_cfg.clip_bottom - i_item.origin_y);
        end else begin
            ch = 13'(gh);
        end

        en = !i_cfg.write_disable && (i_cfg.bytes_per_pixel >= 3'd1)
             && (i_cfg.bytes_per_pixel <= 3'd4) && (13'(ri1) < ch);

        for (int k = 0; k < 8; k++) begin
            emit[k] = en && (xb + 13'(k) < cw)
                      && (!i_item.use_mask || i_item.mask_byte[7-k]);
            sel[k]  = i_item.pattern_byte[7-k];
        end

        ry   = 13'(i_item.origin_y) + 13'(ri1);
        prod = 29'(ry) * 29'(i_cfg.line_stride);

        bi2 = (BIR_W+1)'(bi1) + 1'b1;
        if (CMP_W'(bi2) >= CMP_W'(bpl)) begin
            n_bir = '0;
            n_row = (CMP_W'(ri1) < CMP_W'(gh)) ? ri1 + 1'b1 : ri1;
        end else begin
            n_bir = bi2[BIR_W-1:0];
            n_row = ri1;
        end
    end

    always_comb begin
        o_job.emit    = emit;
        o_job.sel     = sel;
        o_job.x0      = mceb_pkg::X_W'(i_item.origin_x) + mceb_pkg::X_W'(xb);
        o_job.row_off = 32'(prod) + 32'(i_cfg.base_offset);
        o_job.fg      = i_item.fg_color & mceb_pkg::data_mask(i_cfg.bytes_per_pixel);
        o_job.bg      = i_item.bg_color & mceb_pkg::data_mask(i_cfg.bytes_per_pixel);
        o_job.bpp     = i_cfg.bytes_per_pixel;
    end

    // Words with no visible pixel only step the counters.
    assign o_push = accept && (emit != 8'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_bir <= '0;
        end else if (accept) begin
            r_row <= n_row;
            r_bir <= n_bir;
        end
    end

endmodule

`default_nettype wire

// ===== design/mceb_queue.sv =====
// Short queue of classified words between the front and the back end.
// Depends on mceb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mceb_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire mceb_pkg::t_job i_job,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output mceb_pkg::t_job      o_head
);

    localparam int PW = (mceb_pkg::Q_DEPTH > 1) ? $clog2(mceb_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(mceb_pkg::Q_DEPTH + 1);

    mceb_pkg::t_job r_mem [mceb_pkg::Q_DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CW'(mceb_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(mceb_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(mceb_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/mceb_back.sv =====
// Back end of the blitter: walks the visible pixels of the queue head from
// left to right and issues one framebuffer write per cycle into the output
// register while the receiver does not stall. Depends on mceb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mceb_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_head_valid,
    input  wire mceb_pkg::t_job i_head,
    output logic                o_pop,
    input  wire logic           i_out_stall,
    output logic                o_out_valid,
    output mceb_pkg::t_out      o_out_data
);

    logic [7:0]              r_done;
    logic                    r_out_valid;
    mceb_pkg::t_out          r_out;
    mceb_pkg::t_out          n_out;

    logic [7:0]              rem, pick;
    logic [2:0]              k;
    logic                    found, last, fire;
    logic [mceb_pkg::X_W-1:0] xk;
    logic [16:0]             xoff;

    always_comb begin
        rem   = i_head.emit & ~r_done;
        k     = '0;
        found = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (rem[i] && !found) begin
                k     = 3'(i);
                found = 1'b1;
            end
        end
        pick = 8'd1 << k;
        last = ((rem & ~pick) == 8'd0);

        xk   = i_head.x0 + mceb_pkg::X_W'(k);
        xoff = 17'(xk) * 17'(i_head.bpp);

        n_out.write_offset = i_head.row_off + 32'(xoff);
        n_out.write_data   = i_head.sel[k] ? i_head.fg : i_head.bg;
        n_out.write_bytes  = i_head.bpp;
        n_out.last_of_item = last;
    end

    assign fire  = i_head_valid && (!r_out_valid || !i_out_stall);
    assign o_pop = fire && last;

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_done      <= '0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (fire) begin
                r_done <= last ? 8'd0 : (r_done | pick);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== design/mono_color_expand_blitter.sv =====
// Top level of the monochrome color-expansion blitter: configuration
// registers, front end, word queue and back end.
// Depends on mceb_pkg, mceb_front, mceb_queue and mceb_back.
//
// Usage: each input word carries one pattern byte of a 1-bit bitmap, its
// mask byte and the blit header; first_byte starts a new bitmap. Every
// visible pixel of the word becomes one output word: a framebuffer write with
// offset, data, byte count and a flag on the last write of the input word.
// The input channel is taken while the two-entry word queue has room; a word
// with no visible pixel is absorbed and only steps the counters. The first
// write of a word passes the word queue, then the output register. Throughput:
// one write per cycle while the receiver does not stall, limited by the
// single write slot of the output register; a word makes one to eight writes.
// When the receiver stalls, the output word holds and the back end waits;
// the front keeps accepting until the queue fills, then stalls the sender.
// Reset (synchronous, active low) empties the queue and output register,
// clears the row and byte counters and loads the register reset values.
// Configuration is written through a plain write port; the user must do so
// only while the block idles, which the block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module mono_color_expand_blitter #(
    parameter int MAX_GLYPH_WIDTH  = mceb_pkg::DEF_MAX_GLYPH_WIDTH,
    parameter int MAX_GLYPH_HEIGHT = mceb_pkg::DEF_MAX_GLYPH_HEIGHT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [mceb_pkg::CFG_IW-1:0]   i_cfg_index,
    input  wire logic [mceb_pkg::CFG_DW-1:0]   i_cfg_data,
    input  wire logic                          i_in_valid,
    input  wire mceb_pkg::t_in                 i_in_data,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output mceb_pkg::t_out                     o_out_data,
    input  wire logic                          i_out_stall
);

    mceb_pkg::t_cfg r_cfg;
    mceb_pkg::t_job push_job, head_job;
    logic           push, pop, q_full, q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bytes_per_pixel <= mceb_pkg::BPP_RESET;
            r_cfg.line_stride     <= '0;
            r_cfg.clip_right      <= '0;
            r_cfg.clip_bottom     <= '0;
            r_cfg.base_offset     <= '0;
            r_cfg.write_disable   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mceb_pkg::CFG_BYTES_PER_PIXEL: r_cfg.bytes_per_pixel <= i_cfg_data[2:0];
                mceb_pkg::CFG_LINE_STRIDE:     r_cfg.line_stride     <= i_cfg_data[15:0];
                mceb_pkg::CFG_CLIP_RIGHT:      r_cfg.clip_right      <= i_cfg_data[11:0];
                mceb_pkg::CFG_CLIP_BOTTOM:     r_cfg.clip_bottom     <= i_cfg_data[11:0];
                mceb_pkg::CFG_BASE_OFFSET:     r_cfg.base_offset     <= i_cfg_data[23:0];
                mceb_pkg::CFG_WRITE_DISABLE:   r_cfg.write_disable   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    mceb_front #(
        .MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
        .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .i_cfg   (r_cfg),
        .i_full  (q_full),
        .o_stall (o_in_stall),
        .o_push  (push),
        .o_job   (push_job)
    );

    mceb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_job)
    );

    mceb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (head_job),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench of mono_color_expand_blitter: directed and random blits.
// Predicts every framebuffer write from its own model of the counters and registers.
// Depends on mceb_pkg and the mono_color_expand_blitter RTL.
`timescale 1ns / 1ps

module tb;

    localparam int MAX_W        = mceb_pkg::DEF_MAX_GLYPH_WIDTH;
    localparam int MAX_H        = mceb_pkg::DEF_MAX_GLYPH_HEIGHT;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_WORDS = 500;
    localparam int PHASE_WORDS  = 50;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        cfg_we;
    logic [mceb_pkg::CFG_IW-1:0] cfg_index;
    logic [mceb_pkg::CFG_DW-1:0] cfg_data;
    logic                        in_valid;
    mceb_pkg::t_in               in_word;
    logic                        in_stall;
    logic                        out_valid;
    mceb_pkg::t_out              out_word;
    logic                        out_stall;

    // Register and counter copies used by the predictor.
    logic [2:0]  bpp_reg;
    logic [15:0] stride_reg;
    logic [11:0] clip_r_reg;
    logic [11:0] clip_b_reg;
    logic [23:0] base_reg;
    logic        wdis_reg;
    logic [6:0]  row_cnt;
    logic [2:0]  byte_cnt;

    mceb_pkg::t_out expected_writes[$];
    mceb_pkg::t_out head_write;
    int   errors         = 0;
    int   words_sent     = 0;
    int   writes_checked = 0;
    int   settings_used  = 0;
    bit   quiet_phase    = 1'b0;

    mono_color_expand_blitter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_data   (in_word),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_word),
        .i_out_stall (out_stall)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #(10_000_000);
        $display("FAIL");
        $finish;
    end

    function automatic int draw_wait();
        if (quiet_phase) return 0;
        case ($urandom_range(0, 3))
            0, 1:    return 0;
            2:       return $urandom_range(1, 3);
            default: return $urandom_range(0, 18);
        endcase
    endfunction

    function automatic int glyph_size(input logic [6:0] raw, input int limit);
        if (raw == 7'd0) return 1;
        return (int'(raw) > limit) ? limit : int'(raw);
    endfunction

    function automatic int visible_span(input logic [11:0] origin, input int size,
                                        input logic [11:0] lim);
        if (origin >= lim) return 0;
        if (int'(origin) + size > int'(lim)) return int'(lim) - int'(origin);
        return size;
    endfunction

    // Expands one pattern word into its pixel writes and steps the row and byte counters.
    function automatic void predict_writes(input mceb_pkg::t_in w);
        int             gw, gh, bpl, cw, ch, xi;
        logic [31:0]    color, pix_mask;
        mceb_pkg::t_out wr;
        mceb_pkg::t_out burst[$];
        gw  = glyph_size(w.glyph_width, MAX_W);
        gh  = glyph_size(w.glyph_height, MAX_H);
        bpl = (gw + 7) / 8;
        if (w.first_byte) begin
            row_cnt  = '0;
            byte_cnt = '0;
        end
        if (int'(row_cnt) > gh) row_cnt = 7'(gh);
        if (int'(byte_cnt) >= bpl) byte_cnt = '0;
        cw = visible_span(w.origin_x, gw, clip_r_reg);
        ch = visible_span(w.origin_y, gh, clip_b_reg);
        case (bpp_reg)
            3'd1:    pix_mask = 32'h0000_00ff;
            3'd2:    pix_mask = 32'h0000_ffff;
            3'd3:    pix_mask = 32'h00ff_ffff;
            default: pix_mask = 32'hffff_ffff;
        endcase
        if (!wdis_reg && bpp_reg >= 3'd1 && bpp_reg <= 3'd4 && int'(row_cnt) < ch) begin
            for (int k = 0; k < 8; k++) begin
                xi = int'(byte_cnt) * 8 + k;
                if (xi >= cw) break;
                if (!w.use_mask || w.mask_byte[7-k]) begin
                    color = w.pattern_byte[7-k] ? w.fg_color : w.bg_color;
                    wr.write_offset = (32'(w.origin_y) + 32'(row_cnt)) * 32'(stride_reg)
                                    + (32'(w.origin_x) + 32'(xi)) * 32'(bpp_reg)
                                    + 32'(base_reg);
                    wr.write_data   = color & pix_mask;
                    wr.write_bytes  = bpp_reg;
                    wr.last_of_item = 1'b0;
                    burst.push_back(wr);
                end
            end
            if (burst.size() > 0) begin
                wr = burst.pop_back();
                wr.last_of_item = 1'b1;
                burst.push_back(wr);
            end
        end
        foreach (burst[i]) expected_writes.push_back(burst[i]);
        // Counters step even when the word writes nothing.
        if (int'(byte_cnt) + 1 >= bpl) begin
            byte_cnt = '0;
            if (int'(row_cnt) < gh) row_cnt = row_cnt + 7'd1;
        end else begin
            byte_cnt = byte_cnt + 3'd1;
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_writes.size() == 0) begin
                $display("%0t: unexpected write, expected none, actual offset %h data %h",
                         $time, out_word.write_offset, out_word.write_data);
                errors++;
            end else begin
                head_write = expected_writes.pop_front();
                check_field("write_offset", head_write.write_offset, out_word.write_offset);
                check_field("write_data", head_write.write_data, out_word.write_data);
                check_field("write_bytes", 32'(head_write.write_bytes),
                            32'(out_word.write_bytes));
                check_field("last_of_item", 32'(head_write.last_of_item),
                            32'(out_word.last_of_item));
                writes_checked++;
            end
        end
    end

    // Receiver: a random number of stalled cycles before each write is taken.
    initial begin : out_side
        int n;
        out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            n = draw_wait();
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!out_valid);
        end
    end

    task automatic send_word(input mceb_pkg::t_in w);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (in_stall);
        predict_writes(w);
        words_sent++;
    endtask

    // Words without visible pixels leave no trace at the output, so the task keeps
    // waiting even after the last expected write is in.
    task automatic drain_writes();
        in_valid <= 1'b0;
        while (expected_writes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input mceb_pkg::t_cfg_idx idx,
                             input logic [mceb_pkg::CFG_DW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            mceb_pkg::CFG_BYTES_PER_PIXEL: bpp_reg    = val[2:0];
            mceb_pkg::CFG_LINE_STRIDE:     stride_reg = val[15:0];
            mceb_pkg::CFG_CLIP_RIGHT:      clip_r_reg = val[11:0];
            mceb_pkg::CFG_CLIP_BOTTOM:     clip_b_reg = val[11:0];
            mceb_pkg::CFG_BASE_OFFSET:     base_reg   = val[23:0];
            mceb_pkg::CFG_WRITE_DISABLE:   wdis_reg   = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [2:0] bpp, input logic [15:0] stride,
                             input logic [11:0] clip_r, input logic [11:0] clip_b,
                             input logic [23:0] base, input logic wdis);
        drain_writes();
        write_reg(mceb_pkg::CFG_BYTES_PER_PIXEL, mceb_pkg::CFG_DW'(bpp));
        write_reg(mceb_pkg::CFG_LINE_STRIDE, mceb_pkg::CFG_DW'(stride));
        write_reg(mceb_pkg::CFG_CLIP_RIGHT, mceb_pkg::CFG_DW'(clip_r));
        write_reg(mceb_pkg::CFG_CLIP_BOTTOM, mceb_pkg::CFG_DW'(clip_b));
        write_reg(mceb_pkg::CFG_BASE_OFFSET, base);
        write_reg(mceb_pkg::CFG_WRITE_DISABLE, mceb_pkg::CFG_DW'(wdis));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic mceb_pkg::t_in blit_word(input int ox, input int oy,
                                                input int gw, input int gh,
                                                input logic [7:0] pat, input logic [7:0] msk,
                                                input logic um, input logic first);
        mceb_pkg::t_in w;
        w.origin_x     = 12'(ox);
        w.origin_y     = 12'(oy);
        w.glyph_width  = 7'(gw);
        w.glyph_height = 7'(gh);
        w.fg_color     = 32'hA1B2_C3D4;
        w.bg_color     = 32'h5E6F_7081;
        w.pattern_byte = pat;
        w.mask_byte    = msk;
        w.use_mask     = um;
        w.first_byte   = first;
        return w;
    endfunction

    // Reset values: the clip edges are zero, so nothing is drawn until they are opened;
    // the pixel size stays at its reset value of four bytes.
    task automatic test_after_reset();
        mceb_pkg::t_in w;
        w = blit_word(0, 0, 8, 1, 8'hA5, 8'h00, 1'b0, 1'b1);
        send_word(w);
        drain_writes();
        write_reg(mceb_pkg::CFG_CLIP_RIGHT, mceb_pkg::CFG_DW'(12'd4095));
        write_reg(mceb_pkg::CFG_CLIP_BOTTOM, mceb_pkg::CFG_DW'(12'd4095));
        cfg_we <= 1'b0;
        w.fg_color = '1;
        w.bg_color = '0;
        send_word(w);
    endtask

    // Two-byte rows at the far corner with the largest stride and base offset.
    task automatic test_pixel_path();
        configure(3'd4, 16'hffff, 12'd4095, 12'd4095, 24'hff_ffff, 1'b0);
        for (int k = 0; k < 4; k++)
            send_word(blit_word(4088, 4093, 16, 2, 8'(8'h3C ^ (k * 8'h55)), 8'h5A,
                                k == 2, k == 0));
    endtask

    task automatic test_clipping();
        configure(3'd2, 16'd640, 12'd20, 12'd10, 24'd0, 1'b0);
        send_word(blit_word(20, 0, 8, 1, 8'hFF, 8'h00, 1'b0, 1'b1));
        send_word(blit_word(19, 0, 8, 1, 8'hFF, 8'h00, 1'b0, 1'b1));
        send_word(blit_word(0, 10, 8, 1, 8'hFF, 8'h00, 1'b0, 1'b1));
        send_word(blit_word(3, 9, 8, 3, 8'h96, 8'h00, 1'b0, 1'b1));
        send_word(blit_word(3, 9, 8, 3, 8'h69, 8'h00, 1'b0, 1'b0));
    endtask

    // Zero sizes count as one, oversized ones saturate, and words past the bitmap are silent.
    task automatic test_size_limits();
        configure(3'd1, 16'd100, 12'd4095, 12'd4095, 24'd1234, 1'b0);
        send_word(blit_word(5, 5, 0, 0, 8'h80, 8'h00, 1'b0, 1'b1));
        send_word(blit_word(5, 5, 0, 0, 8'hFF, 8'h00, 1'b0, 1'b0));
        send_word(blit_word(1000, 2000, 127, 127, 8'hC3, 8'h00, 1'b0, 1'b1));
        send_word(blit_word(1000, 2000, 127, 127, 8'h3C, 8'h00, 1'b0, 1'b0));
    endtask

    task automatic test_mask();
        configure(3'd3, 16'd192, 12'd4095, 12'd4095, 24'd0, 1'b0);
        send_word(blit_word(7, 7, 8, 1, 8'hFF, 8'h00, 1'b1, 1'b1));
        send_word(blit_word(7, 7, 8, 1, 8'h0F, 8'hFF, 1'b1, 1'b1));
        send_word(blit_word(7, 7, 8, 1, 8'hF0, 8'h5A, 1'b0, 1'b1));
    endtask

    task automatic test_pixel_sizes();
        logic [2:0] bad_sizes[4];
        bad_sizes = '{3'd0, 3'd5, 3'd6, 3'd7};
        foreach (bad_sizes[i]) begin
            configure(bad_sizes[i], 16'd320, 12'd4095, 12'd4095, 24'd16, 1'b0);
            send_word(blit_word(1, 1, 8, 1, 8'hAA, 8'h00, 1'b0, 1'b1));
        end
        configure(3'd2, 16'd0, 12'd4095, 12'd4095, 24'd0, 1'b0);
        send_word(blit_word(1, 1, 8, 1, 8'hAA, 8'h00, 1'b0, 1'b1));
    endtask

    task automatic test_write_disable();
        configure(3'd4, 16'd1024, 12'd4095, 12'd4095, 24'd0, 1'b1);
        send_word(blit_word(0, 0, 8, 1, 8'hFF, 8'h00, 1'b0, 1'b1));
    endtask

    // One whole bitmap of random size and content, sometimes cut short or overrun,
    // and never longer than the words left in the current phase.
    task automatic send_blit(input int max_words);
        mceb_pkg::t_in w;
        int            gw, gh, n_bytes;
        w.fg_color = $urandom;
        w.bg_color = $urandom;
        w.use_mask = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 31))
            0:       w.glyph_width = 7'd0;
            1:       w.glyph_width = 7'($urandom_range(65, 127));
            2, 3:    w.glyph_width = 7'd64;
            default: w.glyph_width = 7'($urandom_range(1, 64));
        endcase
        case ($urandom_range(0, 31))
            0:       w.glyph_height = 7'd0;
            1:       w.glyph_height = 7'($urandom_range(65, 127));
            2:       w.glyph_height = 7'd64;
            default: w.glyph_height = 7'($urandom_range(1, 6));
        endcase
        if ($urandom_range(0, 3) == 0) begin
            w.origin_x = 12'($urandom);
            w.origin_y = 12'($urandom);
        end else begin
            // Keep the origin close inside the clip edges so that most pixels land.
            w.origin_x = 12'((clip_r_reg > 12'd70) ? int'(clip_r_reg) - $urandom_range(1, 70)
                                                   : $urandom_range(0, clip_r_reg));
            w.origin_y = 12'((clip_b_reg > 12'd70) ? int'(clip_b_reg) - $urandom_range(1, 70)
                                                   : $urandom_range(0, clip_b_reg));
        end
        gw      = glyph_size(w.glyph_width, MAX_W);
        gh      = glyph_size(w.glyph_height, MAX_H);
        n_bytes = ((gw + 7) / 8) * gh;
        case ($urandom_range(0, 9))
            0:       n_bytes = $urandom_range(1, n_bytes);
            1:       n_bytes = n_bytes + $urandom_range(1, 8);
            default: ;
        endcase
        if (n_bytes > max_words) n_bytes = max_words;
        for (int k = 0; k < n_bytes; k++) begin
            w.pattern_byte = 8'($urandom);
            w.mask_byte    = 8'($urandom);
            w.first_byte   = (k == 0) || ($urandom_range(0, 49) == 0);
            send_word(w);
        end
    endtask

    task automatic test_random();
        int            start, phase_end;
        mceb_pkg::t_in noise;
        logic [127:0]  raw;
        logic [2:0]    bpp;
        logic [15:0]   stride;
        logic [11:0]   clip_r, clip_b;
        logic [23:0]   base;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            case ($urandom_range(0, 7))
                6:       bpp = 3'($urandom_range(5, 8));  // 8 wraps to the zero size
                7:       bpp = 3'd4;
                default: bpp = 3'($urandom_range(1, 4));
            endcase
            case ($urandom_range(0, 3))
                0:       stride = 16'd0;
                1:       stride = 16'hffff;
                default: stride = 16'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       clip_r = 12'd4095;
                1:       clip_r = 12'($urandom_range(0, 80));
                default: clip_r = 12'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       clip_b = 12'd4095;
                1:       clip_b = 12'($urandom_range(0, 80));
                default: clip_b = 12'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       base = 24'd0;
                1:       base = 24'hff_ffff;
                default: base = 24'($urandom);
            endcase
            configure(bpp, stride, clip_r, clip_b, base, $urandom_range(0, 9) == 0);
            quiet_phase = ($urandom_range(0, 3) == 0);
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end) begin
                if ($urandom_range(0, 9) == 0) begin
                    raw   = {$urandom, $urandom, $urandom, $urandom};
                    noise = raw[$bits(mceb_pkg::t_in)-1:0];
                    send_word(noise);
                end else begin
                    send_blit(phase_end - words_sent);
                end
                // Now and then the sender holds off until every write is out.
                if ($urandom_range(0, 19) == 0) drain_writes();
            end
        end
        quiet_phase = 1'b0;
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_word   <= '0;
        bpp_reg    = mceb_pkg::BPP_RESET;
        stride_reg = '0;
        clip_r_reg = '0;
        clip_b_reg = '0;
        base_reg   = '0;
        wdis_reg   = 1'b0;
        row_cnt    = '0;
        byte_cnt   = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_after_reset();
        test_pixel_path();
        test_clipping();
        test_size_limits();
        test_mask();
        test_pixel_sizes();
        test_write_disable();
        test_random();

        drain_writes();
        $display("Sent %0d pattern words under %0d register settings,", words_sent,
                 settings_used + 1);
        $display("checked %0d pixel writes, %0d failures.", writes_checked, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
